// ===== hw/rtl/vcmi_pkg.sv =====
// Package: shared types and constants of the motion integrator.
package vcmi_pkg;

    localparam int VAL_W  = 32;
    localparam int STEP_W = 16;
    localparam int SPD_W  = 31;
    localparam int SQ_W   = 66;   // sum of three squares of 32-bit magnitudes
    localparam int ROOT_W = 33;

    typedef struct packed {
        logic load;      // latch input transaction, start velocity update
        logic start_sq;  // start sum of squares
        logic start_rt;  // start square root
        logic start_dv;  // start divide of one component
        logic [1:0] comp;
        logic apply_dv;  // write quotient into velocity component
        logic pos_upd;   // start position update
        logic emit;      // load output register
    } vcmi_cmd_t;

    typedef struct packed {
        logic busy;      // multi-cycle unit working
        logic over;      // sum of squares above limit
    } vcmi_sts_t;

endpackage

// ===== hw/rtl/vcmi_datapath.sv =====
// Datapath: velocity/position state, shared step multiplier, square root and divider.
module vcmi_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [vcmi_pkg::SPD_W-1:0]          max_speed,
    input  logic [3*vcmi_pkg::VAL_W-1:0]        accel_in,
    input  logic [vcmi_pkg::STEP_W-1:0]         step_in,
    input  vcmi_pkg::vcmi_cmd_t                 cmd,
    output vcmi_pkg::vcmi_sts_t                 sts,
    output logic [3*vcmi_pkg::VAL_W-1:0]        pos_out,
    output logic [3*vcmi_pkg::VAL_W-1:0]        vel_out
);
    localparam int VW = vcmi_pkg::VAL_W;
    localparam int SW = vcmi_pkg::STEP_W;
    localparam int QW = vcmi_pkg::SQ_W;
    localparam int RW = vcmi_pkg::ROOT_W;

    // unit select codes
    localparam logic [2:0] U_IDLE = 3'd0;
    localparam logic [2:0] U_VEL  = 3'd1;
    localparam logic [2:0] U_SQ   = 3'd2;
    localparam logic [2:0] U_RT   = 3'd3;
    localparam logic [2:0] U_DV   = 3'd4;
    localparam logic [2:0] U_POS  = 3'd5;

    logic signed [VW-1:0] vel_reg [3];
    logic signed [VW-1:0] pos_reg [3];
    logic signed [VW-1:0] acc_reg [3];
    logic [SW-1:0]        step_reg;
    logic [2:0]           unit_reg;
    logic [6:0]           cnt_reg;
    logic [QW-1:0]        sq_reg;
    logic [VW-1:0]        mag_reg;
    // sqrt state
    logic [QW-1:0]        rn_reg;
    logic [QW-1:0]        rr_reg;
    // divide state
    logic [63:0]          num_reg;
    logic [RW-1:0]        rem_reg;
    logic [RW-1:0]        root_reg;
    logic [1:0]           dcomp_reg;
    // multiply pipe
    logic signed [VW+SW:0] prod_reg;
    logic [1:0]            mcomp_reg;
    logic                  mvalid_reg;

    function automatic logic signed [VW-1:0] sat(input logic signed [VW+1:0] x);
        logic signed [VW+1:0] hi;
        logic signed [VW+1:0] lo;
        begin
            hi = (VW+2)'(signed'({1'b0, {(VW-1){1'b1}}}));
            lo = -hi - (VW+2)'(1);
            if (x > hi) sat = hi[VW-1:0];
            else if (x < lo) sat = lo[VW-1:0];
            else sat = x[VW-1:0];
        end
    endfunction

    logic signed [VW-1:0] mop;
    always_comb begin
        mop = (unit_reg == U_VEL) ? acc_reg[cnt_reg[1:0]] : vel_reg[cnt_reg[1:0]];
    end

    // issue a step product while the velocity or position pass has components left
    logic cmd_any;
    logic mul_go;
    always_comb begin
        cmd_any = cmd.load || cmd.start_sq || cmd.start_rt || cmd.start_dv
                  || cmd.apply_dv || cmd.pos_upd;
        mul_go  = !cmd_any && (unit_reg == U_VEL || unit_reg == U_POS) && (cnt_reg < 7'd3);
    end

    // rounded step product: (p + 2^15) >>> 16
    logic signed [VW+SW:0] rnd;
    logic signed [VW:0]    dlt;
    always_comb begin
        rnd = prod_reg + (VW+SW+1)'(1 << (SW-1));
        dlt = rnd[VW+SW:SW];
    end

    logic [VW-1:0] vmag;
    always_comb begin
        vmag = vel_reg[cnt_reg[1:0]][VW-1] ? VW'(-vel_reg[cnt_reg[1:0]])
                                           : vel_reg[cnt_reg[1:0]];
    end

    // sqrt step
    logic [QW-1:0] bitv;
    logic [QW:0]   trial;
    always_comb begin
        bitv  = QW'(1) << {cnt_reg[5:0], 1'b0};
        trial = {1'b0, rn_reg} - ({1'b0, rr_reg} + {1'b0, bitv});
    end

    // divide step (restoring)
    logic [RW:0] dsh;
    logic [RW:0] dsub;
    always_comb begin
        dsh  = {rem_reg, num_reg[63]};
        dsub = dsh - {1'b0, root_reg};
    end

    assign sts.busy = (unit_reg != U_IDLE) || mvalid_reg;
    assign sts.over = sq_reg > QW'({33'd0, max_speed} * {33'd0, max_speed});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            unit_reg   <= U_IDLE;
            mvalid_reg <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                vel_reg[i] <= '0;
                pos_reg[i] <= '0;
            end
        end else begin
            mvalid_reg <= mul_go;
            if (cmd.load) begin
                for (int i = 0; i < 3; i++)
                    acc_reg[i] <= accel_in[i*VW +: VW];
                step_reg <= step_in;
                unit_reg <= U_VEL;
                cnt_reg  <= '0;
            end else if (cmd.start_sq) begin
                unit_reg <= U_SQ;
                cnt_reg  <= '0;
                sq_reg   <= '0;
            end else if (cmd.start_rt) begin
                unit_reg <= U_RT;
                cnt_reg  <= 7'd32;
                rn_reg   <= sq_reg;
                rr_reg   <= '0;
            end else if (cmd.start_dv) begin
                unit_reg  <= U_DV;
                cnt_reg   <= 7'd64;
                dcomp_reg <= cmd.comp;
                num_reg   <= {32'd0, vel_reg[cmd.comp][VW-1] ? VW'(-vel_reg[cmd.comp])
                                                             : vel_reg[cmd.comp]};
                rem_reg   <= '0;
                mag_reg   <= {1'b0, max_speed};
            end else if (cmd.apply_dv) begin
                if (num_reg[63:VW] != '0)
                    vel_reg[dcomp_reg] <= vel_reg[dcomp_reg][VW-1]
                        ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
                else
                    vel_reg[dcomp_reg] <= sat(vel_reg[dcomp_reg][VW-1]
                        ? -(VW+2)'({2'b0, num_reg[VW-1:0]}) : (VW+2)'({2'b0, num_reg[VW-1:0]}));
            end else if (cmd.pos_upd) begin
                unit_reg <= U_POS;
                cnt_reg  <= '0;
            end else begin
                case (unit_reg)
                    U_VEL, U_POS: begin
                        if (cnt_reg < 7'd3) begin
                            prod_reg   <= (VW+SW+1)'(mop) * signed'({1'b0, step_reg});
                            mcomp_reg  <= cnt_reg[1:0];
                            cnt_reg    <= cnt_reg + 7'd1;
                        end
                        if (mvalid_reg) begin
                            if (unit_reg == U_VEL)
                                vel_reg[mcomp_reg] <= sat((VW+2)'(vel_reg[mcomp_reg]) + (VW+2)'(dlt));
                            else
                                pos_reg[mcomp_reg] <= sat((VW+2)'(pos_reg[mcomp_reg]) + (VW+2)'(dlt));
                            if (mcomp_reg == 2'd2) unit_reg <= U_IDLE;
                        end
                    end
                    U_SQ: begin
                        sq_reg  <= sq_reg + QW'(vmag * vmag);
                        cnt_reg <= cnt_reg + 7'd1;
                        if (cnt_reg == 7'd2) unit_reg <= U_IDLE;
                    end
                    U_RT: begin
                        if (!trial[QW]) begin
                            rn_reg <= trial[QW-1:0];
                            rr_reg <= (rr_reg >> 1) + bitv;
                        end else begin
                            rr_reg <= rr_reg >> 1;
                        end
                        if (cnt_reg == 7'd0) unit_reg <= U_IDLE;
                        cnt_reg <= cnt_reg - 7'd1;
                    end
                    U_DV: begin
                        // numerator first scaled by max speed in one multiply
                        if (cnt_reg == 7'd64 && mag_reg != '0) begin
                            num_reg  <= num_reg[VW-1:0] * mag_reg;
                            mag_reg  <= '0;
                            root_reg <= (rr_reg[RW-1:0] == '0) ? RW'(1) : rr_reg[RW-1:0];
                        end else begin
                            if (!dsub[RW]) begin
                                rem_reg <= dsub[RW-1:0];
                                num_reg <= {num_reg[62:0], 1'b1};
                            end else begin
                                rem_reg <= dsh[RW-1:0];
                                num_reg <= {num_reg[62:0], 1'b0};
                            end
                            cnt_reg <= cnt_reg - 7'd1;
                            if (cnt_reg == 7'd1) unit_reg <= U_IDLE;
                        end
                    end
                    default: unit_reg <= U_IDLE;
                endcase
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pos_out[i*VW +: VW] = pos_reg[i];
            vel_out[i*VW +: VW] = vel_reg[i];
        end
    end
endmodule

// ===== hw/rtl/vcmi_ctrl.sv =====
// Controller: sequences velocity update, clamp and position update per transaction.
module vcmi_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                out_free,
    input  vcmi_pkg::vcmi_sts_t sts,
    output vcmi_pkg::vcmi_cmd_t cmd,
    output logic                clamp_flag
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_VEL  = 4'd1;
    localparam logic [3:0] S_SQ   = 4'd2;
    localparam logic [3:0] S_CHK  = 4'd3;
    localparam logic [3:0] S_RT   = 4'd4;
    localparam logic [3:0] S_DVS  = 4'd5;
    localparam logic [3:0] S_DVW  = 4'd6;
    localparam logic [3:0] S_POS  = 4'd7;
    localparam logic [3:0] S_EMIT = 4'd8;

    logic [3:0] state_reg, state_next;
    logic [1:0] comp_reg, comp_next;
    logic       clamp_reg, clamp_next;

    assign in_ready   = (state_reg == S_IDLE);
    assign clamp_flag = clamp_reg;

    always_comb begin
        state_next = state_reg;
        comp_next  = comp_reg;
        clamp_next = clamp_reg;
        cmd        = '0;
        cmd.comp   = comp_reg;
        case (state_reg)
            S_IDLE: if (in_valid) begin
                cmd.load = 1'b1; state_next = S_VEL; clamp_next = 1'b0;
            end
            S_VEL: if (!sts.busy) begin cmd.start_sq = 1'b1; state_next = S_SQ; end
            S_SQ:  if (!sts.busy) state_next = S_CHK;
            S_CHK: if (sts.over) begin
                cmd.start_rt = 1'b1; clamp_next = 1'b1; state_next = S_RT; comp_next = '0;
            end else begin
                cmd.pos_upd = 1'b1; state_next = S_POS;
            end
            S_RT:  if (!sts.busy) state_next = S_DVS;
            S_DVS: begin cmd.start_dv = 1'b1; state_next = S_DVW; end
            S_DVW: if (!sts.busy) begin
                cmd.apply_dv = 1'b1;
                if (comp_reg == 2'd2) begin
                    state_next = S_POS;
                end else begin
                    comp_next = comp_reg + 2'd1; state_next = S_DVS;
                end
            end
            S_POS: if (!sts.busy) begin
                if (clamp_reg && comp_reg == 2'd2) begin
                    cmd.pos_upd = 1'b1; comp_next = '0;
                end else if (out_free) begin
                    cmd.emit = 1'b1; state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            comp_reg  <= '0;
            clamp_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            comp_reg  <= comp_next;
            clamp_reg <= clamp_next;
        end
    end
endmodule

// ===== hw/rtl/velocity_clamped_motion_integrator_core.sv =====
// Sequence: with no clamp, velocity update, sum of squares, limit check, position update
// and result register; when the clamp engages, a 33-step square root, then per component a
// multiply, a 64-step divide and issue and write-back, before the position update.
// Transactions: one at a time; the next is accepted only once the result is registered,
// and output stalls hold back the result register and so the next transaction.
// Reset (aresetn low, synchronous) clears velocity, position, max_speed to 1, control.
module velocity_clamped_motion_integrator_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [111:0] s_tdata,   // accel_x, accel_y, accel_z, step_time
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [199:0] m_tdata,   // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, speed_clamped
    input  logic         cfg_we,
    input  logic [30:0]  cfg_wdata
);
    vcmi_pkg::vcmi_cmd_t cmd;
    vcmi_pkg::vcmi_sts_t sts;
    logic [30:0] max_speed_reg;
    logic [95:0] pos_w, vel_w;
    logic        clamp_w;
    logic        out_free;

    assign out_free = !m_tvalid || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_speed_reg <= 31'd1;
            m_tvalid      <= 1'b0;
        end else begin
            if (cfg_we) max_speed_reg <= (cfg_wdata == '0) ? 31'd1 : cfg_wdata;
            if (cmd.emit) m_tvalid <= 1'b1;
            else if (m_tready) m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) m_tdata <= {7'd0, clamp_w, vel_w, pos_w};
    end

    vcmi_ctrl u_ctrl (
        .aclk, .aresetn, .in_valid(s_tvalid), .in_ready(s_tready),
        .out_free, .sts, .cmd, .clamp_flag(clamp_w)
    );

    vcmi_datapath u_dp (
        .aclk, .aresetn, .max_speed(max_speed_reg), .accel_in(s_tdata[95:0]),
        .step_in(s_tdata[111:96]), .cmd, .sts, .pos_out(pos_w), .vel_out(vel_w)
    );
endmodule

// ===== hw/rtl/vcmi_checker.sv =====
// Checker: port-level properties of the motion integrator, bound to the top level.
module vcmi_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [199:0] m_tdata
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[199:193] == 7'd0) else $error("pad bits set");
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready) else $error("second transaction taken");
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid) else $error("valid after reset");
endmodule

bind velocity_clamped_motion_integrator_core vcmi_checker u_chk (
    .aclk, .aresetn, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata
);

// ===== bench/vcmi_checker.sv =====
// Checker: watches both channels, predicts motion integrator results and compares them.
module vcmi_scoreboard (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [111:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [199:0] m_tdata,
    input  logic         cfg_we,
    input  logic [30:0]  cfg_wdata,
    output int           fail_count,
    output int           pending_count
);
    typedef struct packed {
        logic                              clamped;
        logic signed [vcmi_pkg::VAL_W-1:0] vz, vy, vx, pz, py, px;
    } motion_t;

    motion_t expected_motion[$];
    logic signed [vcmi_pkg::VAL_W-1:0] vel[3];
    logic signed [vcmi_pkg::VAL_W-1:0] pos[3];
    logic [vcmi_pkg::SPD_W-1:0] speed_limit;

    function automatic logic signed [63:0] scale_by_step(logic signed [63:0] v,
                                                         logic [vcmi_pkg::STEP_W-1:0] s);
        logic signed [63:0] p;
        p = v * $signed({48'd0, s});
        return (p + 64'sd32768) >>> 16;
    endfunction

    function automatic logic signed [vcmi_pkg::VAL_W-1:0] saturate(logic signed [63:0] x);
        if (x > 64'sd2147483647) return 32'sh7fffffff;
        if (x < -64'sd2147483648) return 32'sh80000000;
        return x[31:0];
    endfunction

    function automatic logic [vcmi_pkg::ROOT_W-1:0] floor_root(logic [vcmi_pkg::SQ_W-1:0] n);
        logic [vcmi_pkg::SQ_W+1:0] r, b, rem;
        r = 0;
        rem = n;
        b = 68'd1 << 66;
        while (b > rem) b = b >> 2;
        while (b != 0) begin
            if (rem >= r + b) begin
                rem = rem - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r[vcmi_pkg::ROOT_W-1:0];
    endfunction

    function automatic motion_t integrate(logic [111:0] d);
        logic [vcmi_pkg::STEP_W-1:0] s;
        logic [vcmi_pkg::SQ_W-1:0] sumsq, lim;
        logic [63:0] mag, q, m;
        motion_t r;
        s = d[111:96];
        sumsq = 0;
        for (int i = 0; i < 3; i++)
            vel[i] = saturate(64'(vel[i]) + scale_by_step(64'($signed(d[32*i +: 32])), s));
        for (int i = 0; i < 3; i++) begin
            mag = vel[i] < 0 ? -64'(vel[i]) : 64'(vel[i]);
            sumsq = sumsq + vcmi_pkg::SQ_W'(mag) * vcmi_pkg::SQ_W'(mag);
        end
        lim = vcmi_pkg::SQ_W'(speed_limit) * vcmi_pkg::SQ_W'(speed_limit);
        r.clamped = sumsq > lim;
        if (r.clamped) begin
            m = 64'(floor_root(sumsq));
            if (m == 0) m = 1;
            for (int i = 0; i < 3; i++) begin
                mag = vel[i] < 0 ? -64'(vel[i]) : 64'(vel[i]);
                q = (mag * 64'(speed_limit)) / m;
                vel[i] = saturate(vel[i] < 0 ? -$signed(q) : $signed(q));
            end
        end
        for (int i = 0; i < 3; i++)
            pos[i] = saturate(64'(pos[i]) + scale_by_step(64'(vel[i]), s));
        r.px = pos[0]; r.py = pos[1]; r.pz = pos[2];
        r.vx = vel[0]; r.vy = vel[1]; r.vz = vel[2];
        return r;
    endfunction

    always @(posedge aclk) begin
        motion_t exp_m, got;
        if (!aresetn) begin
            speed_limit <= 1;
            for (int i = 0; i < 3; i++) begin
                vel[i] = 0;
                pos[i] = 0;
            end
            fail_count    <= 0;
            pending_count <= 0;
        end else begin
            if (cfg_we) speed_limit <= (cfg_wdata == 0) ? 31'd1 : cfg_wdata;
            if (s_tvalid && s_tready) expected_motion.push_back(integrate(s_tdata));
            if (m_tvalid && m_tready) begin
                got = m_tdata[192:0];
                if (expected_motion.size() == 0) begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10) $display("unexpected result transaction %h", got);
                end else begin
                    exp_m = expected_motion.pop_front();
                    if (got !== exp_m || m_tdata[199:193] !== 0) begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display("mismatch: expected %h actual %h", exp_m, m_tdata);
                    end
                end
            end
            pending_count <= expected_motion.size();
        end
    end
endmodule

// ===== bench/velocity_clamped_motion_integrator_core_test.sv =====
// Testbench top: drives transactions and configuration, gives the verdict.
module velocity_clamped_motion_integrator_core_test;
    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [111:0] s_tdata = 0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [199:0] m_tdata;
    logic         cfg_we = 0;
    logic [30:0]  cfg_wdata = 0;
    int           fail_count, pending_count;
    bit           steady;

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    velocity_clamped_motion_integrator_core dut (.*);

    vcmi_scoreboard checker_i (.*);

    // Randomly stall the result side, except during the steady stretch.
    always @(posedge aclk) m_tready <= steady || ($urandom_range(99) >= 35);

    function automatic logic [31:0] pick_accel();
        case ($urandom_range(5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom;
            default: return $signed($urandom_range(2000000)) - 1000000;
        endcase
    endfunction

    function automatic logic [15:0] pick_step();
        case ($urandom_range(4))
            0: return 16'hffff;
            1: return 16'h0000;
            2: return 16'($urandom);
            default: return 16'($urandom_range(6554));
        endcase
    endfunction

    // Hold valid across back-to-back transactions; outside the steady stretch, drop it at random.
    task automatic send_motion(logic [31:0] ax, ay, az, logic [15:0] s);
        if (!steady && $urandom_range(99) < 35) begin
            s_tvalid <= 0;
            do @(posedge aclk); while ($urandom_range(99) < 35);
        end
        s_tvalid <= 1;
        s_tdata  <= {s, az, ay, ax};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain_and_set_limit(logic [30:0] v);
        s_tvalid <= 0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        cfg_we    <= 1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 0;
    endtask

    initial begin
        logic [30:0] limits[6] = '{31'd0, 31'h7fffffff, 31'd65536, 31'd1,
                                   31'd3000000, 31'd200000};
        repeat (3) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        // directed: extremes of fields, with default limit of one LSB
        send_motion(32'h7fffffff, 32'h80000000, 0, 16'hffff);
        send_motion(0, 0, 0, 16'h0000);
        send_motion(32'h80000000, 32'h80000000, 32'h80000000, 16'hffff);
        drain_and_set_limit(31'h7fffffff);
        for (int i = 0; i < 8; i++)
            send_motion(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 16'hffff);
        for (int i = 0; i < 8; i++)
            send_motion(32'h80000000, 32'h7fffffff, 32'h80000000, 16'hffff);
        send_motion(32'h00010000, 32'hffff0000, 0, 16'h8000);
        // random phases across the limit settings
        foreach (limits[p]) begin
            drain_and_set_limit(limits[p]);
            steady = (p == 2);
            for (int i = 0; i < 275; i++)
                send_motion(pick_accel(), pick_accel(), pick_accel(), pick_step());
            steady = 0;
        end
        s_tvalid <= 0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #40000000;
        $display("Simulation FAILED");
        $finish;
    end
endmodule

// ===== sim.f =====
hw/rtl/vcmi_pkg.sv
hw/rtl/vcmi_datapath.sv
hw/rtl/vcmi_ctrl.sv
hw/rtl/velocity_clamped_motion_integrator_core.sv
hw/rtl/vcmi_checker.sv
bench/vcmi_checker.sv
bench/velocity_clamped_motion_integrator_core_test.sv
